/* rtl/core/tpsp_pkg.sv */
package tpsp_pkg;

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [7:0]  PMT_TABLE_ID    = 8'h02;
	localparam logic [11:0] MIN_SECTION_LEN = 12'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  es_type;
		logic [12:0] es_pid;
		logic [12:0] pcr_pid;
		logic [15:0] program_number;
		logic [4:0]  version;
	} result_t;

	typedef struct packed {
		logic  step;
		item_t item;
	} step_t;

endpackage

/* rtl/core/tpsp_in_if.sv */
interface tpsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

/* rtl/core/tpsp_out_if.sv */
interface tpsp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  es_type_out;
	logic [12:0] es_pid;
	logic [12:0] pcr_pid_out;
	logic [15:0] program_number;
	logic [4:0]  version_out;

	modport source (output valid, output kind, output es_type_out, output es_pid,
		output pcr_pid_out, output program_number, output version_out, input ready);
	modport sink (input valid, input kind, input es_type_out, input es_pid,
		input pcr_pid_out, input program_number, input version_out, output ready);
endinterface

/* rtl/core/ts_pmt_section_parser.sv */
// Parses one program map section from a PSI payload that arrives one byte per transaction,
// starting with the pointer field (first_byte set) and ending where last_byte is set. One
// result transaction is produced per elementary stream entry, with its stream type and PID,
// and one final transaction after the CRC bytes reports the section as ok or in error; a
// section length below the minimum yields the error result at the end of the header, and a
// buffer that ends early yields the error result on its last byte. The CRC is not verified.
// A byte is accepted every cycle unless input is stalled, and its result is offered once the
// parse step has moved it from the input register into the result register. Downstream
// backpressure holds the result register and stalls input once the input register is full.
module ts_pmt_section_parser (
	input  logic       clk,
	input  logic       arst_n,
	tpsp_in_if.sink    bytes,
	tpsp_out_if.source results
);

	logic               valid_s1;
	tpsp_pkg::item_t    item_s1;
	logic               advance;
	tpsp_pkg::step_t    step;
	logic               res_valid;
	tpsp_pkg::result_t  res;
	logic               out_valid_q;
	tpsp_pkg::result_t  out_q;

	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.data_byte  <= bytes.data_byte;
			item_s1.first_byte <= bytes.first_byte;
			item_s1.last_byte  <= bytes.last_byte;
		end
	end

	assign step.step = advance;
	assign step.item = item_s1;

	tpsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.kind           = out_q.kind;
	assign results.es_type_out    = out_q.es_type;
	assign results.es_pid         = out_q.es_pid;
	assign results.pcr_pid_out    = out_q.pcr_pid;
	assign results.program_number = out_q.program_number;
	assign results.version_out    = out_q.version;

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.kind == tpsp_pkg::KIND_ENTRY ||
			results.kind == tpsp_pkg::KIND_OK || results.kind == tpsp_pkg::KIND_ERROR))
		else $error("result kind out of range");

	a_final_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind != tpsp_pkg::KIND_ENTRY) |->
			(results.es_type_out == 8'd0 && results.es_pid == 13'd0))
		else $error("final result carries entry fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled byte");

	a_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes.ready)
		else $error("input not ready while input register empty");

endmodule

/* rtl/core/tpsp_parser.sv */
module tpsp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  tpsp_pkg::step_t    step,
	output logic               res_valid,
	output tpsp_pkg::result_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SKIP,
		PH_HDR,
		PH_PINFO,
		PH_DESC,
		PH_ETYPE,
		PH_EWORD,
		PH_DRAIN,
		PH_CRC,
		PH_DONE
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [9:0]  skip_q, n_skip;
	logic [11:0] left_q, n_left;
	logic [2:0]  idx_q, n_idx;
	logic [31:0] word_q, n_word;
	logic [7:0]  tid_q, n_tid;
	logic [12:0] pcr_q, n_pcr;
	logic [15:0] prog_q, n_prog;
	logic [4:0]  ver_q, n_ver;
	logic [7:0]  type_q, n_type;
	logic        failed_q, n_failed;
	logic        do_settle;
	logic        final_given;
	logic        hit;
	logic [1:0]  hit_kind;
	logic [7:0]  hit_type;
	logic [12:0] hit_pid;
	logic [7:0]  b;

	function automatic logic word_ok(input logic [31:0] w);
		word_ok = (w[31:29] == 3'h7) && (w[15:12] == 4'hF) && (w[11:10] == 2'h0);
	endfunction

	assign b = step.item.data_byte;

	always_comb begin
		n_phase     = phase_q;
		n_skip      = skip_q;
		n_left      = left_q;
		n_idx       = idx_q;
		n_word      = word_q;
		n_tid       = tid_q;
		n_pcr       = pcr_q;
		n_prog      = prog_q;
		n_ver       = ver_q;
		n_type      = type_q;
		n_failed    = failed_q;
		do_settle   = 1'b0;
		final_given = 1'b0;
		hit         = 1'b0;
		hit_kind    = tpsp_pkg::KIND_ENTRY;
		hit_type    = 8'd0;
		hit_pid     = 13'd0;

		if (step.item.first_byte) begin
			n_phase  = (b != 8'd0) ? PH_SKIP : PH_HDR;
			n_skip   = {2'b00, b};
			n_left   = 12'd0;
			n_idx    = 3'd0;
			n_word   = 32'd0;
			n_tid    = 8'd0;
			n_pcr    = 13'd0;
			n_prog   = 16'd0;
			n_ver    = 5'd0;
			n_type   = 8'd0;
			n_failed = 1'b0;
		end else begin
			unique case (phase_q) inside
				PH_SKIP: begin
					n_skip = skip_q - 10'd1;
					if (n_skip == 10'd0) begin
						n_phase = PH_HDR;
					end
				end
				PH_HDR: begin
					n_idx = idx_q + 3'd1;
					case (idx_q) inside
						3'd0: n_tid = b;
						3'd1, 3'd2: n_word = {16'd0, word_q[7:0], b};
						3'd3, 3'd4: n_prog = {prog_q[7:0], b};
						3'd5: n_ver = b[5:1];
						default: ;
					endcase
					if (idx_q == 3'd2) begin
						n_left = n_word[11:0];
					end
					if (idx_q == 3'd7) begin
						if (left_q < tpsp_pkg::MIN_SECTION_LEN) begin
							hit         = 1'b1;
							hit_kind    = tpsp_pkg::KIND_ERROR;
							final_given = 1'b1;
							n_phase     = PH_DONE;
						end else begin
							n_left    = left_q - tpsp_pkg::MIN_SECTION_LEN;
							n_idx     = 3'd0;
							n_word    = 32'd0;
							n_phase   = PH_PINFO;
							do_settle = 1'b1;
						end
					end
				end
				PH_PINFO, PH_EWORD: begin
					n_word    = {word_q[23:0], b};
					n_left    = left_q - 12'd1;
					n_idx     = idx_q + 3'd1;
					do_settle = 1'b1;
					if (idx_q == 3'd3) begin
						if (!word_ok(n_word)) begin
							n_failed = 1'b1;
							n_phase  = PH_DRAIN;
						end else begin
							if (phase_q == PH_PINFO) begin
								n_pcr = n_word[28:16];
							end else begin
								hit      = 1'b1;
								hit_kind = tpsp_pkg::KIND_ENTRY;
								hit_type = type_q;
								hit_pid  = n_word[28:16];
							end
							if ({2'b00, n_word[9:0]} > n_left) begin
								n_failed = 1'b1;
								n_phase  = PH_DRAIN;
							end else begin
								n_skip  = n_word[9:0];
								n_phase = PH_DESC;
							end
						end
					end
				end
				PH_DESC: begin
					n_skip    = skip_q - 10'd1;
					n_left    = left_q - 12'd1;
					do_settle = 1'b1;
				end
				PH_ETYPE: begin
					n_type    = b;
					n_left    = left_q - 12'd1;
					n_idx     = 3'd0;
					n_word    = 32'd0;
					n_phase   = PH_EWORD;
					do_settle = 1'b1;
				end
				PH_DRAIN: begin
					n_left    = left_q - 12'd1;
					do_settle = 1'b1;
				end
				PH_CRC: begin
					n_idx = idx_q + 3'd1;
					if (idx_q == 3'd3) begin
						hit         = 1'b1;
						hit_kind    = (!failed_q && tid_q == tpsp_pkg::PMT_TABLE_ID) ?
							tpsp_pkg::KIND_OK : tpsp_pkg::KIND_ERROR;
						final_given = 1'b1;
						n_phase     = PH_DONE;
					end
				end
				PH_IDLE, PH_DONE: ;
				default: ;
			endcase
		end

		if (do_settle) begin
			if (n_phase == PH_DESC && n_skip == 10'd0) begin
				n_phase = PH_ETYPE;
			end
			if (n_left == 12'd0) begin
				case (n_phase) inside
					PH_PINFO, PH_EWORD: begin
						n_failed = 1'b1;
						n_phase  = PH_CRC;
						n_idx    = 3'd0;
					end
					PH_DESC, PH_ETYPE, PH_DRAIN: begin
						n_phase = PH_CRC;
						n_idx   = 3'd0;
					end
					default: ;
				endcase
			end
		end

		// An early end of the buffer replaces whatever this byte would give.
		if (step.item.last_byte && !final_given && n_phase != PH_IDLE && n_phase != PH_DONE) begin
			hit      = 1'b1;
			hit_kind = tpsp_pkg::KIND_ERROR;
			hit_type = 8'd0;
			hit_pid  = 13'd0;
			n_phase  = PH_DONE;
		end
	end

	assign res_valid          = step.step && hit;
	assign res.kind           = hit_kind;
	assign res.es_type        = hit_type;
	assign res.es_pid         = hit_pid;
	assign res.pcr_pid        = n_pcr;
	assign res.program_number = n_prog;
	assign res.version        = n_ver;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			skip_q   <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			word_q   <= '0;
			tid_q    <= '0;
			pcr_q    <= '0;
			prog_q   <= '0;
			ver_q    <= '0;
			type_q   <= '0;
			failed_q <= 1'b0;
		end else if (step.step) begin
			phase_q  <= n_phase;
			skip_q   <= n_skip;
			left_q   <= n_left;
			idx_q    <= n_idx;
			word_q   <= n_word;
			tid_q    <= n_tid;
			pcr_q    <= n_pcr;
			prog_q   <= n_prog;
			ver_q    <= n_ver;
			type_q   <= n_type;
			failed_q <= n_failed;
		end
	end

endmodule
